// File: rtl/fvcw_pkg.sv
// Shared types, constants and the color wheel lookup for the flow color coder.
// Used by every cell module and by the top level; depends on nothing.
`default_nettype none

package fvcw_pkg;

    localparam int FLOW_FRAC_BITS = 8;
    localparam int WHEEL_ENTRIES  = 55;
    localparam int CORDIC_STEPS   = 15;
    localparam int SQRT_STEPS     = 24;
    localparam int QUO_BITS       = 8;
    localparam int MAG_W          = 24;
    localparam int LIM_W          = 16 + FLOW_FRAC_BITS;
    localparam int NUM_W          = 32;
    localparam int BLEND_W        = 24;

    localparam logic [15:0] ATAN_TURNS [CORDIC_STEPS] = '{
        16'd8192, 16'd4836, 16'd2555, 16'd1297, 16'd651, 16'd326, 16'd163, 16'd81,
        16'd41, 16'd20, 16'd10, 16'd5, 16'd3, 16'd1, 16'd1
    };

    localparam logic [7:0] RAMP6 [6]   = '{8'd0, 8'd42, 8'd85, 8'd127, 8'd170, 8'd212};
    localparam logic [7:0] RAMP4 [4]   = '{8'd0, 8'd63, 8'd127, 8'd191};
    localparam logic [7:0] RAMP11 [11] = '{
        8'd0, 8'd23, 8'd46, 8'd69, 8'd92, 8'd115, 8'd139, 8'd162, 8'd185, 8'd208, 8'd231
    };
    localparam logic [7:0] RAMP13 [13] = '{
        8'd0, 8'd19, 8'd39, 8'd58, 8'd78, 8'd98, 8'd117, 8'd137, 8'd156, 8'd176,
        8'd196, 8'd215, 8'd235
    };

    typedef struct packed {
        logic signed [15:0] flow_x;
        logic signed [15:0] flow_y;
        logic               flow_valid;
    } fvcw_vec_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } fvcw_rgb_t;

    typedef struct packed {
        logic               fv;
        logic               axis;
        logic signed [26:0] cx;
        logic signed [26:0] cy;
        logic [15:0]        acc;
        logic [47:0]        op;
        logic [24:0]        rem;
        logic [MAG_W-1:0]   root;
    } fvcw_lane_t;

    // channel index 0 red, 1 green, 2 blue
    typedef struct packed {
        logic                  fv;
        logic                  inr;
        logic [2:0][NUM_W-1:0] num;
        logic [2:0][7:0]       quo;
        logic [2:0][7:0]       alt;
    } fvcw_div_t;

    function automatic logic [2:0][7:0] wheel_rgb(input logic [5:0] k);
        logic [2:0][7:0] c;
        logic [5:0]      i;
        c = '0;
        i = '0;
        if (k < 6'd15)
        begin
            i    = k;
            c[0] = 8'd255;
            c[1] = 8'(i) * 8'd17;
            c[2] = 8'd0;
        end
        else if (k < 6'd21)
        begin
            i    = k - 6'd15;
            c[0] = 8'd255 - RAMP6[i[2:0]];
            c[1] = 8'd255;
            c[2] = 8'd0;
        end
        else if (k < 6'd25)
        begin
            i    = k - 6'd21;
            c[0] = 8'd0;
            c[1] = 8'd255;
            c[2] = RAMP4[i[1:0]];
        end
        else if (k < 6'd36)
        begin
            i    = k - 6'd25;
            c[0] = 8'd0;
            c[1] = 8'd255 - RAMP11[i[3:0]];
            c[2] = 8'd255;
        end
        else if (k < 6'd49)
        begin
            i    = k - 6'd36;
            c[0] = RAMP13[i[3:0]];
            c[1] = 8'd0;
            c[2] = 8'd255;
        end
        else
        begin
            i    = k - 6'd49;
            c[0] = 8'd255;
            c[1] = 8'd0;
            c[2] = 8'd255 - RAMP6[i[2:0]];
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/flow_vector_color_wheel.sv
// Optical-flow color coder: one flow vector in, one BGR pixel out, one beat per clock
// sustained. Stages: input stage, square sum, 15 angle cells, 24 square
// root cells, wheel position, wheel blend, scaling product, 8 divide cells, output
// register. The pipeline holds while a result beat is stalled at the output.
// Depends on fvcw_pkg, fvcw_cordic_cell, fvcw_sqrt_cell and fvcw_div_cell.
`default_nettype none

module flow_vector_color_wheel
    import fvcw_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic      vec_valid,
    output logic           vec_stall,
    input  wire fvcw_vec_t vec,
    output logic           rgb_valid,
    input  wire logic      rgb_stall,
    output fvcw_rgb_t      rgb
);

    logic              adv;
    logic [15:0]       radius_reg;
    logic [15:0]       radius_eff;
    logic [LIM_W-1:0]  lim;

    logic signed [16:0] x17;
    logic signed [16:0] y17;
    logic signed [16:0] ax;
    logic signed [16:0] ay;
    logic signed [31:0] px;
    logic signed [31:0] py;

    logic               s1_vld_reg;
    logic               s1_fv_reg;
    logic               s1_axis_reg;
    logic signed [26:0] s1_cx_reg;
    logic signed [26:0] s1_cy_reg;
    logic [15:0]        s1_acc_reg;
    logic [30:0]        s1_sqx_reg;
    logic [30:0]        s1_sqy_reg;

    logic               s2_vld_reg;
    fvcw_lane_t         s2_lane_reg;
    fvcw_lane_t         s2_lane_next;

    logic               cor_vld [CORDIC_STEPS+1];
    fvcw_lane_t         cor_lane [CORDIC_STEPS+1];
    logic               sq_vld [SQRT_STEPS+1];
    fvcw_lane_t         sq_lane [SQRT_STEPS+1];

    logic [15:0]        phase;
    logic [21:0]        pos;
    logic               p_vld_reg;
    logic               p_fv_reg;
    logic [5:0]         p_k0_reg;
    logic [15:0]        p_frac_reg;
    logic [MAG_W-1:0]   p_mag_reg;

    logic [5:0]              k1;
    logic [2:0][7:0]         c0;
    logic [2:0][7:0]         c1;
    logic [2:0][BLEND_W-1:0] blend_next;
    logic                    w_vld_reg;
    logic                    w_fv_reg;
    logic [MAG_W-1:0]        w_mag_reg;
    logic [2:0][BLEND_W-1:0] w_blend_reg;

    logic               m_vld_reg;
    fvcw_div_t          m_div_reg;
    fvcw_div_t          m_div_next;
    logic [47:0]        prod [3];

    logic               dv_vld [QUO_BITS+1];
    fvcw_div_t          dv_div [QUO_BITS+1];

    logic               out_vld_reg;
    fvcw_rgb_t          out_reg;
    fvcw_rgb_t          out_next;
    logic [2:0][7:0]    pick;

    assign adv       = !(out_vld_reg && rgb_stall);
    assign vec_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= 16'd2560;
        else if (cfg_we)
            radius_reg <= cfg_wdata;
    end

    assign radius_eff = (radius_reg == 16'd0) ? 16'd1 : radius_reg;
    assign lim        = {radius_eff, {FLOW_FRAC_BITS{1'b0}}};

    // input stage: fold the left half plane, square the components
    always_comb
    begin
        x17 = {vec.flow_x[15], vec.flow_x};
        y17 = {vec.flow_y[15], vec.flow_y};
        ax  = vec.flow_x[15] ? -x17 : x17;
        ay  = vec.flow_x[15] ? -y17 : y17;
        px  = vec.flow_x * vec.flow_x;
        py  = vec.flow_y * vec.flow_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            p_vld_reg  <= 1'b0;
            w_vld_reg  <= 1'b0;
            m_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg  <= vec_valid;
            s2_vld_reg  <= s1_vld_reg;
            p_vld_reg   <= sq_vld[SQRT_STEPS];
            w_vld_reg   <= p_vld_reg;
            m_vld_reg   <= w_vld_reg;
            out_vld_reg <= dv_vld[QUO_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_fv_reg   <= vec.flow_valid;
            s1_axis_reg <= (vec.flow_y == 16'sd0) && !vec.flow_x[15];
            s1_cx_reg   <= {{2{ax[16]}}, ax, 8'b0};
            s1_cy_reg   <= {{2{ay[16]}}, ay, 8'b0};
            s1_acc_reg  <= vec.flow_x[15] ? 16'h8000 : 16'h0000;
            s1_sqx_reg  <= px[30:0];
            s1_sqy_reg  <= py[30:0];
        end
    end

    always_comb
    begin
        s2_lane_next      = '0;
        s2_lane_next.fv   = s1_fv_reg;
        s2_lane_next.axis = s1_axis_reg;
        s2_lane_next.cx   = s1_cx_reg;
        s2_lane_next.cy   = s1_cy_reg;
        s2_lane_next.acc  = s1_acc_reg;
        s2_lane_next.op   = {32'({1'b0, s1_sqx_reg} + {1'b0, s1_sqy_reg}), 16'b0};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            s2_lane_reg <= s2_lane_next;
    end

    assign cor_vld[0]  = s2_vld_reg;
    assign cor_lane[0] = s2_lane_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        fvcw_cordic_cell #(.STEP(i)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .up_vld  (cor_vld[i]),
            .up_lane (cor_lane[i]),
            .dn_vld  (cor_vld[i+1]),
            .dn_lane (cor_lane[i+1])
        );
    end

    assign sq_vld[0]  = cor_vld[CORDIC_STEPS];
    assign sq_lane[0] = cor_lane[CORDIC_STEPS];

    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_sqrt
        fvcw_sqrt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .up_vld  (sq_vld[j]),
            .up_lane (sq_lane[j]),
            .dn_vld  (sq_vld[j+1]),
            .dn_lane (sq_lane[j+1])
        );
    end

    // wheel position
    always_comb
    begin
        phase = sq_lane[SQRT_STEPS].axis ? 16'h0000 : sq_lane[SQRT_STEPS].acc;
        pos   = 22'(phase) * 22'(WHEEL_ENTRIES - 1);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_fv_reg   <= sq_lane[SQRT_STEPS].fv;
            p_k0_reg   <= pos[21:16];
            p_frac_reg <= pos[15:0];
            p_mag_reg  <= sq_lane[SQRT_STEPS].root;
        end
    end

    // blend the two neighboring wheel entries
    always_comb
    begin
        k1 = (p_k0_reg == 6'(WHEEL_ENTRIES - 1)) ? 6'd0 : p_k0_reg + 6'd1;
        c0 = wheel_rgb(p_k0_reg);
        c1 = wheel_rgb(k1);
        for (int ch = 0; ch < 3; ch++)
        begin
            blend_next[ch] = BLEND_W'((25'(17'h10000 - {1'b0, p_frac_reg}) * 25'(c0[ch]))
                                     + (25'(p_frac_reg) * 25'(c1[ch])));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w_fv_reg    <= p_fv_reg;
            w_mag_reg   <= p_mag_reg;
            w_blend_reg <= blend_next;
        end
    end

    // scale by magnitude, or by three quarters past the radius
    always_comb
    begin
        m_div_next     = '0;
        m_div_next.fv  = w_fv_reg;
        m_div_next.inr = (w_mag_reg <= lim);
        for (int ch = 0; ch < 3; ch++)
        begin
            prod[ch]              = 48'(w_blend_reg[ch]) * 48'(w_mag_reg);
            m_div_next.num[ch]    = prod[ch][47:16];
            m_div_next.alt[ch]    = 8'((26'(w_blend_reg[ch]) * 26'd3) >> 18);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            m_div_reg <= m_div_next;
    end

    assign dv_vld[0] = m_vld_reg;
    assign dv_div[0] = m_div_reg;

    for (genvar b = 0; b < QUO_BITS; b++)
    begin : g_div
        fvcw_div_cell #(.BIT(QUO_BITS - 1 - b)) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (adv),
            .lim    (lim),
            .up_vld (dv_vld[b]),
            .up_div (dv_div[b]),
            .dn_vld (dv_vld[b+1]),
            .dn_div (dv_div[b+1])
        );
    end

    always_comb
    begin
        pick = dv_div[QUO_BITS].inr ? dv_div[QUO_BITS].quo : dv_div[QUO_BITS].alt;
        if (!dv_div[QUO_BITS].fv)
            pick = '0;
        out_next.red   = pick[0];
        out_next.green = pick[1];
        out_next.blue  = pick[2];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= out_next;
    end

    assign rgb_valid = out_vld_reg;
    assign rgb       = out_reg;

    a_invalid_black : assert property (@(posedge clk) disable iff (!rst_n)
        (adv && dv_vld[QUO_BITS] && !dv_div[QUO_BITS].fv) |=> (rgb == '0))
        else $error("invalid vector did not give a black pixel");

    a_outside_dim : assert property (@(posedge clk) disable iff (!rst_n)
        (adv && dv_vld[QUO_BITS] && dv_div[QUO_BITS].fv && !dv_div[QUO_BITS].inr)
        |=> (rgb.red <= 8'd191 && rgb.green <= 8'd191 && rgb.blue <= 8'd191))
        else $error("pixel beyond radius brighter than three quarters");

    a_div_rem : assert property (@(posedge clk) disable iff (!rst_n)
        (dv_vld[QUO_BITS] && dv_div[QUO_BITS].fv && dv_div[QUO_BITS].inr)
        |-> (dv_div[QUO_BITS].num[0] < NUM_W'(lim) && dv_div[QUO_BITS].num[1] < NUM_W'(lim)
             && dv_div[QUO_BITS].num[2] < NUM_W'(lim)))
        else $error("scaling quotient overflowed eight bits");

endmodule

`default_nettype wire

// File: rtl/fvcw_cordic_cell.sv
// One vectoring rotation of the angle chain: rotate toward the x axis, update phase.
// Depends on fvcw_pkg.
`default_nettype none

module fvcw_cordic_cell
    import fvcw_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire logic       up_vld,
    input  wire fvcw_lane_t up_lane,
    output logic            dn_vld,
    output fvcw_lane_t      dn_lane
);

    logic               vld_reg;
    fvcw_lane_t         lane_reg;
    fvcw_lane_t         lane_next;
    logic signed [26:0] xs;
    logic signed [26:0] ys;

    always_comb
    begin
        xs        = up_lane.cx >>> STEP;
        ys        = up_lane.cy >>> STEP;
        lane_next = up_lane;
        if (up_lane.cy > 27'sd0)
        begin
            lane_next.cx  = up_lane.cx + ys;
            lane_next.cy  = up_lane.cy - xs;
            lane_next.acc = up_lane.acc + ATAN_TURNS[STEP];
        end
        else
        begin
            lane_next.cx  = up_lane.cx - ys;
            lane_next.cy  = up_lane.cy + xs;
            lane_next.acc = up_lane.acc - ATAN_TURNS[STEP];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= up_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            lane_reg <= lane_next;
    end

    assign dn_vld  = vld_reg;
    assign dn_lane = lane_reg;

endmodule

`default_nettype wire

// File: rtl/fvcw_sqrt_cell.sv
// One result bit of the magnitude square root, digit by digit.
// Depends on fvcw_pkg.
`default_nettype none

module fvcw_sqrt_cell
    import fvcw_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire logic       up_vld,
    input  wire fvcw_lane_t up_lane,
    output logic            dn_vld,
    output fvcw_lane_t      dn_lane
);

    logic        vld_reg;
    fvcw_lane_t  lane_reg;
    fvcw_lane_t  lane_next;
    logic [26:0] rem_t;
    logic [26:0] trial;

    always_comb
    begin
        rem_t     = {up_lane.rem, up_lane.op[47:46]};
        trial     = {1'b0, up_lane.root, 2'b01};
        lane_next = up_lane;
        lane_next.op = {up_lane.op[45:0], 2'b00};
        if (rem_t >= trial)
        begin
            lane_next.rem  = 25'(rem_t - trial);
            lane_next.root = {up_lane.root[MAG_W-2:0], 1'b1};
        end
        else
        begin
            lane_next.rem  = rem_t[24:0];
            lane_next.root = {up_lane.root[MAG_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= up_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            lane_reg <= lane_next;
    end

    assign dn_vld  = vld_reg;
    assign dn_lane = lane_reg;

endmodule

`default_nettype wire

// File: rtl/fvcw_div_cell.sv
// One quotient bit of the saturation scaling for all three channels.
// Depends on fvcw_pkg.
`default_nettype none

module fvcw_div_cell
    import fvcw_pkg::*;
#(
    parameter int BIT = 7
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic [LIM_W-1:0] lim,
    input  wire logic             up_vld,
    input  wire fvcw_div_t        up_div,
    output logic                  dn_vld,
    output fvcw_div_t             dn_div
);

    logic           vld_reg;
    fvcw_div_t      div_reg;
    fvcw_div_t      div_next;
    logic [NUM_W:0] trial;

    always_comb
    begin
        trial    = (NUM_W + 1)'(lim) << BIT;
        div_next = up_div;
        for (int ch = 0; ch < 3; ch++)
        begin
            if ({1'b0, up_div.num[ch]} >= trial)
            begin
                div_next.num[ch]      = NUM_W'({1'b0, up_div.num[ch]} - trial);
                div_next.quo[ch][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= up_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            div_reg <= div_next;
    end

    assign dn_vld = vld_reg;
    assign dn_div = div_reg;

endmodule

`default_nettype wire
